/* hdl/crpp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crpp_pkg
// Shared types, constants and arithmetic helpers of the cone ray projection.
// ----------------------------------------------------------------------------
package crpp_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int COORD_BITS_DEF = 32;

	// Q30 working width: holds signed values in [-8, 8)
	localparam int Q_W = 34;
	typedef logic signed [Q_W-1:0] q_t;

	localparam q_t ONE_Q30 = 34'sd1073741824;
	localparam logic [30:0] ONE_U30 = 31'd1073741824;

	// sine polynomial over a quarter turn, Q30, highest order first
	localparam logic [30:0] POLY_C0 = 31'd3864;
	localparam logic [30:0] POLY_C1 = 31'd172272;
	localparam logic [30:0] POLY_C2 = 31'd5026995;
	localparam logic [30:0] POLY_C3 = 31'd85569306;
	localparam logic [30:0] POLY_C4 = 31'd693598668;
	localparam logic [30:0] POLY_C5 = 31'd1686629713;

	localparam int SINE_STAGES = 8;
	localparam int ROT_STAGES  = 4;

	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BEAM_THETA     = 3'd0,
		REG_BEAM_PHI       = 3'd1,
		REG_BEAM_X         = 3'd2,
		REG_BEAM_Y         = 3'd3,
		REG_PLANE_DISTANCE = 3'd4
	} reg_idx_t;

	// unsigned Q30 product, truncated
	function automatic logic [30:0] qmul_u(input logic [30:0] a, input logic [30:0] b);
		logic [61:0] p;
		p = a * b;
		return p[60:30];
	endfunction

	function automatic logic [30:0] horner(input logic [30:0] u2, input logic [30:0] p,
			input logic [30:0] c);
		return c - qmul_u(u2, p);
	endfunction

	// signed Q30 product, truncated toward zero
	function automatic q_t mulq(input q_t a, input q_t b);
		logic signed [2*Q_W-1:0] p;
		logic signed [2*Q_W-1:0] r;
		p = a * b;
		if (p < 0) begin
			r = -((-p) >>> 30);
		end else begin
			r = p >>> 30;
		end
		return r[Q_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* hdl/crpp_sine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crpp_sine
// Pipelined sine of a binary angle: quadrant fold, Horner polynomial, sign.
// ----------------------------------------------------------------------------
module crpp_sine import crpp_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic [SINE_STAGES-1:0] en,
	input  logic [ANGLE_BITS-1:0]  angle,
	output q_t                     sine
);

	logic [29:0] frac;
	logic [30:0] u_s1, u_s2, u_s3, u_s4, u_s5, u_s6, u_s7;
	logic [30:0] u2_s2, u2_s3, u2_s4, u2_s5, u2_s6;
	logic [30:0] p_s3, p_s4, p_s5, p_s6, p_s7;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [30:0] mag;

	assign frac = {angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			u_s1   <= angle[ANGLE_BITS-2] ? ONE_U30 - {1'b0, frac} : {1'b0, frac};
			neg_s1 <= angle[ANGLE_BITS-1];
		end
		if (en[1]) begin
			u2_s2  <= qmul_u(u_s1, u_s1);
			u_s2   <= u_s1;
			neg_s2 <= neg_s1;
		end
		if (en[2]) begin
			p_s3   <= horner(u2_s2, POLY_C0, POLY_C1);
			u2_s3  <= u2_s2;
			u_s3   <= u_s2;
			neg_s3 <= neg_s2;
		end
		if (en[3]) begin
			p_s4   <= horner(u2_s3, p_s3, POLY_C2);
			u2_s4  <= u2_s3;
			u_s4   <= u_s3;
			neg_s4 <= neg_s3;
		end
		if (en[4]) begin
			p_s5   <= horner(u2_s4, p_s4, POLY_C3);
			u2_s5  <= u2_s4;
			u_s5   <= u_s4;
			neg_s5 <= neg_s4;
		end
		if (en[5]) begin
			p_s6   <= horner(u2_s5, p_s5, POLY_C4);
			u2_s6  <= u2_s5;
			u_s6   <= u_s5;
			neg_s6 <= neg_s5;
		end
		if (en[6]) begin
			p_s7   <= horner(u2_s6, p_s6, POLY_C5);
			u_s7   <= u_s6;
			neg_s7 <= neg_s6;
		end
		if (en[7]) begin
			sine <= neg_s7 ? -q_t'({3'b000, mag}) : q_t'({3'b000, mag});
		end
	end

	always_comb begin
		mag = qmul_u(u_s7, p_s7);
		if (mag > ONE_U30) begin
			mag = ONE_U30;
		end
	end

endmodule
`default_nettype wire

/* hdl/crpp_rotate.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crpp_rotate
// Builds the ray vector, rotates it by the transposed beam matrix and forms
// the scaled plane distance.
// ----------------------------------------------------------------------------
module crpp_rotate import crpp_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic [ROT_STAGES-1:0]        en,
	input  q_t                           ct,
	input  q_t                           st,
	input  q_t                           cp,
	input  q_t                           sp,
	input  q_t                           sc,
	input  q_t                           cc,
	input  q_t                           ca,
	input  q_t                           sa,
	input  logic [COORD_BITS-2:0]        plane_distance,
	output q_t                           w0,
	output q_t                           w1,
	output q_t                           w2,
	output logic signed [COORD_BITS-1:0] len
);

	q_t cp2_s1, spcp_s1, sp2_s1, r20_s1, r21_s1, v0_s1, v1_s1, ct_s1, cc_s1, ctm1_s1;
	q_t r00_s2, r01_s2, r11_s2, r20_s2, r21_s2, v0_s2, v1_s2, cc_s2, ct_s2;
	q_t m00_s3, m01_s3, m02_s3, m10_s3, m11_s3, m12_s3, m20_s3, m21_s3, m22_s3;
	logic signed [COORD_BITS-1:0] len_s2, len_s3;
	logic signed [COORD_BITS+33:0] lp, lt;

	always_comb begin
		lp = $signed({1'b0, plane_distance}) * ct_s1;
		if (lp < 0) begin
			lt = -((-lp) >>> 30);
		end else begin
			lt = lp >>> 30;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cp2_s1  <= mulq(cp, cp);
			spcp_s1 <= mulq(sp, cp);
			sp2_s1  <= mulq(sp, sp);
			r20_s1  <= mulq(st, cp);
			r21_s1  <= mulq(st, sp);
			v0_s1   <= mulq(sc, ca);
			v1_s1   <= mulq(sc, sa);
			ct_s1   <= ct;
			cc_s1   <= cc;
			ctm1_s1 <= ct - ONE_Q30;
		end
		if (en[1]) begin
			r00_s2 <= ONE_Q30 + mulq(ctm1_s1, cp2_s1);
			r01_s2 <= mulq(ctm1_s1, spcp_s1);
			r11_s2 <= ONE_Q30 + mulq(ctm1_s1, sp2_s1);
			r20_s2 <= r20_s1;
			r21_s2 <= r21_s1;
			v0_s2  <= v0_s1;
			v1_s2  <= v1_s1;
			cc_s2  <= cc_s1;
			ct_s2  <= ct_s1;
			len_s2 <= lt[COORD_BITS-1:0];
		end
		if (en[2]) begin
			m00_s3 <= mulq(r00_s2, v0_s2);
			m01_s3 <= mulq(r01_s2, v1_s2);
			m02_s3 <= mulq(r20_s2, cc_s2);
			m10_s3 <= mulq(r01_s2, v0_s2);
			m11_s3 <= mulq(r11_s2, v1_s2);
			m12_s3 <= mulq(r21_s2, cc_s2);
			m20_s3 <= mulq(r20_s2, v0_s2);
			m21_s3 <= mulq(r21_s2, v1_s2);
			m22_s3 <= mulq(ct_s2, cc_s2);
			len_s3 <= len_s2;
		end
		if (en[3]) begin
			w0  <= m00_s3 + m01_s3 + m02_s3;
			w1  <= m10_s3 + m11_s3 + m12_s3;
			w2  <= m22_s3 - m20_s3 - m21_s3;
			len <= len_s3;
		end
	end

endmodule
`default_nettype wire

/* hdl/crpp_divide.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crpp_divide
// Projects both ray components onto the plane: exact product, one quotient
// bit per stage, then sign, origin offset and saturation.
// ----------------------------------------------------------------------------
module crpp_divide import crpp_pkg::*; #(
	parameter  int COORD_BITS = COORD_BITS_DEF,
	localparam int QW         = COORD_BITS + 1,
	localparam int ND         = QW + 3
) (
	input  logic                         clk,
	input  logic [ND-1:0]                en,
	input  logic signed [COORD_BITS-1:0] len,
	input  q_t                           w0,
	input  q_t                           w1,
	input  q_t                           w2,
	input  logic signed [COORD_BITS-1:0] beam_x,
	input  logic signed [COORD_BITS-1:0] beam_y,
	output logic signed [COORD_BITS-1:0] hit_x,
	output logic signed [COORD_BITS-1:0] hit_y,
	output logic                         no_hit
);

	typedef struct packed {
		logic [32:0]    rem;
		logic [QW-1:0]  low;
		logic [QW-1:0]  quo;
		logic           neg;
		logic           ovf;
	} lane_t;

	typedef struct packed {
		lane_t       x;
		lane_t       y;
		logic [32:0] d;
		logic        no_hit;
	} div_t;

	localparam logic [COORD_BITS-1:0] SAT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [COORD_BITS-1:0] SAT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	function automatic lane_t step(input lane_t l, input logic [32:0] d);
		lane_t       r;
		logic [33:0] t;
		r = l;
		t = {l.rem, l.low[QW-1]};
		r.low = {l.low[QW-2:0], 1'b0};
		if (t >= {1'b0, d}) begin
			r.rem = 33'(t - {1'b0, d});
			r.quo = {l.quo[QW-2:0], 1'b1};
		end else begin
			r.rem = t[32:0];
			r.quo = {l.quo[QW-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [COORD_BITS-1:0] finish(input lane_t l,
			input logic signed [COORD_BITS-1:0] base);
		logic signed [COORD_BITS+1:0] sv;
		logic signed [COORD_BITS+1:0] sum;
		logic [COORD_BITS-1:0]        res;
		sv  = $signed({2'b00, l.quo[COORD_BITS-1:0]});
		sum = (l.neg ? -sv : sv) + {{2{base[COORD_BITS-1]}}, base};
		if (l.ovf || l.quo[QW-1]) begin
			res = l.neg ? SAT_MIN : SAT_MAX;
		end else if (sum[COORD_BITS+1:COORD_BITS-1] == 3'b000 ||
				sum[COORD_BITS+1:COORD_BITS-1] == 3'b111) begin
			res = sum[COORD_BITS-1:0];
		end else begin
			res = sum[COORD_BITS+1] ? SAT_MIN : SAT_MAX;
		end
		return res;
	endfunction

	logic [COORD_BITS-1:0]  a;
	logic [32:0]            bx, by;
	logic [COORD_BITS+32:0] px_s1, py_s1;
	logic [32:0]            d_s1;
	logic                   nx_s1, ny_s1, nh_s1;
	div_t                   init;
	div_t                   step_s [0:QW];

	assign a  = len[COORD_BITS-1] ? COORD_BITS'(-len) : COORD_BITS'(len);
	assign bx = w0[Q_W-1] ? 33'(-w0) : 33'(w0);
	assign by = w1[Q_W-1] ? 33'(-w1) : 33'(w1);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			px_s1 <= {33'd0, a} * {{COORD_BITS{1'b0}}, bx};
			py_s1 <= {33'd0, a} * {{COORD_BITS{1'b0}}, by};
			d_s1  <= w2[32:0];
			nx_s1 <= len[COORD_BITS-1] != w0[Q_W-1];
			ny_s1 <= len[COORD_BITS-1] != w1[Q_W-1];
			nh_s1 <= w2[Q_W-1] || (w2 == '0);
		end
	end

	always_comb begin
		init.d      = d_s1;
		init.no_hit = nh_s1;
		init.x.rem  = {1'b0, px_s1[COORD_BITS+32:QW]};
		init.x.low  = px_s1[QW-1:0];
		init.x.quo  = '0;
		init.x.neg  = nx_s1;
		init.x.ovf  = {1'b0, px_s1[COORD_BITS+32:QW]} >= d_s1;
		init.y.rem  = {1'b0, py_s1[COORD_BITS+32:QW]};
		init.y.low  = py_s1[QW-1:0];
		init.y.quo  = '0;
		init.y.neg  = ny_s1;
		init.y.ovf  = {1'b0, py_s1[COORD_BITS+32:QW]} >= d_s1;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			step_s[0] <= init;
		end
		for (int k = 1; k <= QW; k++) begin
			if (en[k+1]) begin
				step_s[k].x      <= step(step_s[k-1].x, step_s[k-1].d);
				step_s[k].y      <= step(step_s[k-1].y, step_s[k-1].d);
				step_s[k].d      <= step_s[k-1].d;
				step_s[k].no_hit <= step_s[k-1].no_hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[ND-1]) begin
			no_hit <= step_s[QW].no_hit;
			hit_x  <= step_s[QW].no_hit ? '0 : finish(step_s[QW].x, beam_x);
			hit_y  <= step_s[QW].no_hit ? '0 : finish(step_s[QW].y, beam_y);
		end
	end

endmodule
`default_nettype wire

/* hdl/cone_ray_plane_projection_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cone_ray_plane_projection_unit
// Projects a photon ray, given by cone angle and azimuth around a configured
// beam, onto the detector plane.
// ----------------------------------------------------------------------------
// channel  signals                                   transfer at
// in       in_valid in_ready cone_angle azimuth      in_valid & in_ready
// out      out_valid out_ready hit_x hit_y no_hit    out_valid & out_ready
// cfg      cfg_valid cfg_ready cfg_index cfg_data    cfg_valid & cfg_ready
//
// One item per cycle while the output is not stalled; the pipe is made of
// the sine pipelines (8), the rotation (4) and the bit-per-stage divider.
// Reset clears stage valid bits and the beam registers to zero.
// A stalled output stage holds; earlier stages keep filling bubbles, so input
// is refused only when every stage is occupied.
// ----------------------------------------------------------------------------
module cone_ray_plane_projection_unit import crpp_pkg::*; #(
	parameter  int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter  int COORD_BITS = COORD_BITS_DEF,
	localparam int CFG_W      = (ANGLE_BITS > COORD_BITS) ? ANGLE_BITS : COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ANGLE_BITS-1:0]        cone_angle,
	input  logic [ANGLE_BITS-1:0]        azimuth,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] hit_x,
	output logic signed [COORD_BITS-1:0] hit_y,
	output logic                         no_hit,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_data
);

	localparam int ND = COORD_BITS + 4;
	localparam int N  = SINE_STAGES + ROT_STAGES + ND;
	localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};

	logic [ANGLE_BITS-1:0]        beam_theta_q, beam_phi_q;
	logic signed [COORD_BITS-1:0] beam_x_q, beam_y_q;
	logic [COORD_BITS-2:0]        plane_distance_q;

	logic [N-1:0] valid_s;
	logic [N-1:0] en;

	q_t ct, st, cp, sp, sc, cc, ca, sa;
	q_t w0, w1, w2;
	logic signed [COORD_BITS-1:0] len;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_theta_q     <= '0;
			beam_phi_q       <= '0;
			beam_x_q         <= '0;
			beam_y_q         <= '0;
			plane_distance_q <= '0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_BEAM_THETA:     beam_theta_q     <= cfg_data[ANGLE_BITS-1:0];
				REG_BEAM_PHI:       beam_phi_q       <= cfg_data[ANGLE_BITS-1:0];
				REG_BEAM_X:         beam_x_q         <= cfg_data[COORD_BITS-1:0];
				REG_BEAM_Y:         beam_y_q         <= cfg_data[COORD_BITS-1:0];
				REG_PLANE_DISTANCE: plane_distance_q <= cfg_data[COORD_BITS-2:0];
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or its successor advances
	always_comb begin
		en[N-1] = !valid_s[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !valid_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (en[0]) begin
				valid_s[0] <= in_valid;
			end
			for (int k = 1; k < N; k++) begin
				if (en[k]) begin
					valid_s[k] <= valid_s[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = valid_s[N-1];

	crpp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_ct (
		.clk(clk), .en(en[SINE_STAGES-1:0]), .angle(beam_theta_q + QUARTER), .sine(ct));
	crpp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_st (
		.clk(clk), .en(en[SINE_STAGES-1:0]), .angle(beam_theta_q), .sine(st));
	crpp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_cp (
		.clk(clk), .en(en[SINE_STAGES-1:0]), .angle(beam_phi_q + QUARTER), .sine(cp));
	crpp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_sp (
		.clk(clk), .en(en[SINE_STAGES-1:0]), .angle(beam_phi_q), .sine(sp));
	crpp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_sc (
		.clk(clk), .en(en[SINE_STAGES-1:0]), .angle(cone_angle), .sine(sc));
	crpp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_cc (
		.clk(clk), .en(en[SINE_STAGES-1:0]), .angle(cone_angle + QUARTER), .sine(cc));
	crpp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_ca (
		.clk(clk), .en(en[SINE_STAGES-1:0]), .angle(azimuth + QUARTER), .sine(ca));
	crpp_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_sa (
		.clk(clk), .en(en[SINE_STAGES-1:0]), .angle(azimuth), .sine(sa));

	crpp_rotate #(.COORD_BITS(COORD_BITS)) u_rotate (
		.clk            (clk),
		.en             (en[SINE_STAGES +: ROT_STAGES]),
		.ct             (ct),
		.st             (st),
		.cp             (cp),
		.sp             (sp),
		.sc             (sc),
		.cc             (cc),
		.ca             (ca),
		.sa             (sa),
		.plane_distance (plane_distance_q),
		.w0             (w0),
		.w1             (w1),
		.w2             (w2),
		.len            (len)
	);

	crpp_divide #(.COORD_BITS(COORD_BITS)) u_divide (
		.clk    (clk),
		.en     (en[SINE_STAGES+ROT_STAGES +: ND]),
		.len    (len),
		.w0     (w0),
		.w1     (w1),
		.w2     (w2),
		.beam_x (beam_x_q),
		.beam_y (beam_y_q),
		.hit_x  (hit_x),
		.hit_y  (hit_y),
		.no_hit (no_hit)
	);

endmodule
`default_nettype wire

/* hdl/crpp_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crpp_checker
// Port-level checks of the projection unit, bound to its top level.
// ----------------------------------------------------------------------------
module crpp_checker import crpp_pkg::*; #(
	parameter  int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter  int COORD_BITS = COORD_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [ANGLE_BITS-1:0]        cone_angle,
	input logic [ANGLE_BITS-1:0]        azimuth,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [COORD_BITS-1:0] hit_x,
	input logic signed [COORD_BITS-1:0] hit_y,
	input logic                         no_hit,
	input logic                         cfg_valid,
	input logic                         cfg_ready
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit_x) && $stable(hit_y)
			&& $stable(no_hit))
		else $error("stalled result changed");

	// hold a waiting input transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(cone_angle) && $stable(azimuth))
		else $error("waiting input changed");

	a_no_hit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_hit |-> hit_x == '0 && hit_y == '0)
		else $error("missed ray with nonzero coordinates");

	// input is refused only behind a stalled output
	a_refuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused without output stall");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration transfer refused");

endmodule

bind cone_ray_plane_projection_unit crpp_checker #(
	.ANGLE_BITS (ANGLE_BITS),
	.COORD_BITS (COORD_BITS)
) u_crpp_checker (.*);
`default_nettype wire

/* verif/cone_ray_plane_projection_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cone_ray_plane_projection_unit_tb
// Streams photon rays through the projection unit under several beam setups,
// predicts each plane hit in fixed point and checks every result transfer.
// ----------------------------------------------------------------------------
module cone_ray_plane_projection_unit_tb;
	import crpp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;
	localparam longint COORD_HI = 64'sd2147483647;
	localparam longint COORD_LO = -64'sd2147483648;

	typedef struct {
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic               no_hit;
	} hit_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [15:0]         cone_angle = '0;
	logic [15:0]         azimuth = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic signed [31:0]  hit_x;
	logic signed [31:0]  hit_y;
	logic                no_hit;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_BEAM_THETA;
	logic [31:0]         cfg_data = '0;

	logic [15:0] beam_theta, beam_phi;
	longint      beam_x, beam_y, plane_dist;
	hit_t        hits_due[$];
	int          errors = 0;
	bit          quiet = 1'b0;
	int          ready_hold = 0;

	cone_ray_plane_projection_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cone_angle(cone_angle), .azimuth(azimuth),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit_x(hit_x), .hit_y(hit_y), .no_hit(no_hit),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic longint unsigned sine_quarter(longint unsigned u);
		longint unsigned u2, p;
		u2 = (u * u) >> 30;
		p = 3864;
		p = 172272 - ((u2 * p) >> 30);
		p = 5026995 - ((u2 * p) >> 30);
		p = 85569306 - ((u2 * p) >> 30);
		p = 693598668 - ((u2 * p) >> 30);
		p = 1686629713 - ((u2 * p) >> 30);
		p = (u * p) >> 30;
		if (p > 64'd1073741824) p = 64'd1073741824;
		return p;
	endfunction

	function automatic longint sine_of(logic [15:0] a);
		longint unsigned u;
		longint s;
		u = longint'(a[13:0]) << 16;
		if (a[14]) u = 64'd1073741824 - u;
		s = longint'(sine_quarter(u));
		return a[15] ? -s : s;
	endfunction

	function automatic longint cosine_of(logic [15:0] a);
		return sine_of(a + 16'h4000);
	endfunction

	function automatic longint qmul(longint a, longint b);
		longint p;
		p = a * b;
		return (p >= 0) ? (p >>> 30) : -((-p) >>> 30);
	endfunction

	function automatic logic signed [31:0] land_on_plane(longint len, longint w, longint d,
			longint base);
		logic [127:0] num, quo;
		longint unsigned ua, ub, mag;
		longint sv;
		ua = (len < 0) ? -len : len;
		ub = (w < 0) ? -w : w;
		num = {64'd0, ua} * {64'd0, ub};
		quo = num / {64'd0, d};
		mag = (quo > 128'd4611686018427387904) ? 64'd4611686018427387904 : quo[63:0];
		sv = (((len < 0) != (w < 0)) ? -longint'(mag) : longint'(mag)) + base;
		if (sv > COORD_HI) sv = COORD_HI;
		if (sv < COORD_LO) sv = COORD_LO;
		return sv[31:0];
	endfunction

	function automatic hit_t project_ray(logic [15:0] cone, logic [15:0] az);
		longint ct, st, cp, sp, sc, cc, ca, sa, ctm1;
		longint r00, r01, r11, r20, r21, v0, v1, v2, w0, w1, w2, len;
		hit_t h;
		ct = cosine_of(beam_theta); st = sine_of(beam_theta);
		cp = cosine_of(beam_phi);   sp = sine_of(beam_phi);
		sc = sine_of(cone);         cc = cosine_of(cone);
		ca = cosine_of(az);         sa = sine_of(az);
		ctm1 = ct - 64'sd1073741824;
		r00 = 64'sd1073741824 + qmul(ctm1, qmul(cp, cp));
		r01 = qmul(ctm1, qmul(sp, cp));
		r11 = 64'sd1073741824 + qmul(ctm1, qmul(sp, sp));
		r20 = qmul(st, cp);
		r21 = qmul(st, sp);
		v0 = qmul(sc, ca); v1 = qmul(sc, sa); v2 = cc;
		w0 = qmul(r00, v0) + qmul(r01, v1) + qmul(r20, v2);
		w1 = qmul(r01, v0) + qmul(r11, v1) + qmul(r21, v2);
		w2 = -qmul(r20, v0) - qmul(r21, v1) + qmul(ct, v2);
		if (w2 <= 0) begin
			h.hit_x = '0; h.hit_y = '0; h.no_hit = 1'b1;
			return h;
		end
		len = qmul(plane_dist, ct);
		h.hit_x = land_on_plane(len, w0, w2, beam_x);
		h.hit_y = land_on_plane(len, w1, w2, beam_y);
		h.no_hit = 1'b0;
		return h;
	endfunction

	task automatic mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// result side: random stall bursts unless quiet
	always @(posedge clk) begin
		if (quiet) begin
			out_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			ready_hold = $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		hit_t want;
		if (arst_n && out_valid && out_ready) begin
			if (hits_due.size() == 0) begin
				mismatch("unexpected transfer", hit_x, 0);
			end else begin
				want = hits_due.pop_front();
				if (hit_x !== want.hit_x) mismatch("hit_x", hit_x, want.hit_x);
				if (hit_y !== want.hit_y) mismatch("hit_y", hit_y, want.hit_y);
				if (no_hit !== want.no_hit) mismatch("no_hit", no_hit, want.no_hit);
			end
		end
	end

	task automatic send_ray(logic [15:0] cone, logic [15:0] az);
		int gap;
		cfg_valid <= 1'b0;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cone_angle <= cone;
		azimuth <= az;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		hits_due.insert(hits_due.size(), project_ray(cone, az));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (hits_due.size() != 0) @(posedge clk);
	endtask

	// cfg_valid stays high between writes; the next ray transfer drops it
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_BEAM_THETA:     beam_theta = data[15:0];
			REG_BEAM_PHI:       beam_phi = data[15:0];
			REG_BEAM_X:         beam_x = longint'(signed'(data));
			REG_BEAM_Y:         beam_y = longint'(signed'(data));
			REG_PLANE_DISTANCE: plane_dist = longint'(data[30:0]);
			default: ;
		endcase
	endtask

	task automatic set_beam(logic [15:0] th, logic [15:0] ph, logic [31:0] x, logic [31:0] y,
			logic [31:0] d);
		drain();
		write_reg(REG_BEAM_THETA, {16'd0, th});
		write_reg(REG_BEAM_PHI, {16'd0, ph});
		write_reg(REG_BEAM_X, x);
		write_reg(REG_BEAM_Y, y);
		write_reg(REG_PLANE_DISTANCE, d);
	endtask

	task automatic test_reset_state();
		send_ray(16'h0000, 16'h0000);
		send_ray(16'h0800, 16'h1234);
		send_ray(16'h8000, 16'h0000);
	endtask

	task automatic test_angle_extremes();
		set_beam(16'h0000, 16'h0000, 32'h0001_0000, 32'hFFFF_0000, 32'h000A_0000);
		send_ray(16'h0000, 16'hFFFF);
		send_ray(16'hFFFF, 16'h0000);
		send_ray(16'h4000, 16'h4000);
		send_ray(16'h3FFF, 16'h8000);
		send_ray(16'h8000, 16'hC000);
		send_ray(16'hC000, 16'h2000);
		send_ray(16'h1000, 16'h5555);
		send_ray(16'hF000, 16'hAAAA);
	endtask

	task automatic test_saturation();
		set_beam(16'h0000, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_ray(16'h3FFF, 16'h0000);
		send_ray(16'h3FFF, 16'h8000);
		send_ray(16'h3FF0, 16'h4000);
		send_ray(16'h0001, 16'h0000);
		set_beam(16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_ray(16'h0000, 16'h0000);
		send_ray(16'h2000, 16'h6000);
		send_ray(16'h3FFF, 16'hE000);
	endtask

	task automatic test_unused_index();
		set_beam(16'h1000, 16'h3000, 32'h0002_0000, 32'h0003_0000, 32'h0040_0000);
		write_reg(REG_UNUSED, 32'hDEAD_BEEF);
		write_reg(REG_SPARE, 32'h1234_5678);
		send_ray(16'h0400, 16'h0100);
		send_ray(16'h7000, 16'h9000);
		send_ray(16'h0000, 16'h0000);
	endtask

	task automatic test_random_rays();
		logic [15:0] cone;
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: set_beam(16'h0000, 16'h0000, '0, '0, 32'h0010_0000);
				1: set_beam(16'hFFFF, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
				2: set_beam(16'h0000, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0);
				default: set_beam(16'($urandom_range(0, 16'h1800)) ^
						{1'($urandom_range(0, 1)), 15'd0},
						16'($urandom), $urandom, $urandom,
						{1'b0, 31'($urandom)} >> $urandom_range(0, 12));
			endcase
			if (phase == 6) quiet = 1'b1;
			for (int i = 0; i < 200; i++) begin
				cone = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h3000));
				send_ray(cone, 16'($urandom));
				if (phase == 3 && i == 100) drain();
			end
		end
	endtask

	initial begin
		beam_theta = '0; beam_phi = '0;
		beam_x = 0; beam_y = 0; plane_dist = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_angle_extremes();
		test_saturation();
		test_unused_index();
		test_random_rays();
		drain();
		repeat (80) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
